@@ hw/rtl/abd_pkg.sv @@
// Package for the ADC ladder button decoder: widths, level reset values,
// the sequencer state type, the sample type and the level array type. No dependencies.
package abd_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 16;
   localparam int CNT_W      = 4;
   localparam int CODE_W     = 3;
   localparam int NUM_LEVELS = 8;
   localparam int NUM_CH     = 2;
   localparam int MAP_W      = NUM_CH * CODE_W;
   localparam int CSR_IDX_W  = 4;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef sample_type level_array_type [NUM_LEVELS];

   localparam sample_type LEVEL_RESET [NUM_LEVELS] = '{
      12'd4095, 12'd1490, 12'd2358, 12'd1125,
      12'd3160, 12'd1280, 12'd1872, 12'd1002
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_ACCUM,
      ST_WIN,
      ST_SEARCH,
      ST_RESOLVE,
      ST_EMIT
   } state_type;

endpackage

@@ hw/rtl/adc_ladder_button_decoder.sv @@
// Top level of the ADC ladder button decoder (abd_pkg, abd_fifo, abd_back): level registers,
// item queue, back end, result queue. An item that opens a window is accumulated directly; one
// inside a window first runs the serial mean divider for the jump test; one that closes it also
// runs a second division and an 8-step level search. One item at a time, the next taken once the
// last result is pushed, while results drain; two items queue ahead, two results behind. Synchronous
// active-high reset restores default levels, clears sums, count and held map, empties queues.
module adc_ladder_button_decoder
   import abd_pkg::*;
#(
   parameter int SAMPLES    = 10,
   parameter int JUMP_LIMIT = 100
) (
   input  logic                 clock,
   input  logic                 reset,
   // item side
   input  logic                 push,
   output logic                 full,
   input  logic [SAMPLE_W-1:0]  req_sample_a,
   input  logic [SAMPLE_W-1:0]  req_sample_b,
   // result side
   output logic                 empty,
   input  logic                 pop,
   output logic [MAP_W-1:0]     rsp_button_map,
   output logic                 rsp_map_updated,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata
);

   localparam int QUEUE_DEPTH = 2;

   level_array_type        level_ff;
   logic                   in_empty;
   logic                   in_pop;
   logic [2*SAMPLE_W-1:0]  in_data;
   logic                   out_full;
   logic                   out_push;
   logic [MAP_W:0]         out_data;
   logic [MAP_W:0]         rsp_data;

   // Register writes are always taken; an index past the last level is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_LEVELS))) begin
         level_ff[csr_index[CODE_W-1:0]] <= csr_wdata;
      end
   end

   // Front: hold incoming sample pairs until the back end is free.
   abd_fifo #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_in_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .wdata ({req_sample_a, req_sample_b}),
      .pop   (in_pop),
      .empty (in_empty),
      .rdata (in_data)
   );

   // Back: jump test, window accumulation and nearest-level decode.
   abd_back #(
      .SAMPLES    (SAMPLES),
      .JUMP_LIMIT (JUMP_LIMIT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_empty (in_empty),
      .in_pop   (in_pop),
      .in_data  (in_data),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data),
      .levels   (level_ff)
   );

   // Result queue: lets the back end finish while the consumer stalls.
   abd_fifo #(
      .WIDTH (MAP_W + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_data),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_data)
   );

   assign rsp_button_map  = rsp_data[MAP_W:1];
   assign rsp_map_updated = rsp_data[0];

endmodule

@@ hw/rtl/abd_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; used for the item queue and the result queue.
module abd_fifo #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ hw/rtl/abd_divider.sv @@
// Restoring serial divider, one quotient bit per cycle, for the running means.
// Depends on abd_pkg.
module abd_divider
   import abd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  dq_ff, dq_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              ge;

   assign trial    = {rem_ff, dq_ff[SUM_W-1]};
   assign ge       = (trial >= {1'b0, div_ff});
   assign diff     = trial - {1'b0, div_ff};
   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dq_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         // load operands
         busy_in = 1'b1;
         step_in = '0;
         dq_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift in one bit, subtract where it fits
         dq_in   = {dq_ff[SUM_W-2:0], ge};
         rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

endmodule

@@ hw/rtl/abd_back.sv @@
// Back end of the decoder: jump test, window sums and nearest-level search.
// Depends on abd_pkg and abd_divider.
module abd_back
   import abd_pkg::*;
#(
   parameter int SAMPLES    = 10,
   parameter int JUMP_LIMIT = 100
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_empty,
   output logic                     in_pop,
   input  logic [2*SAMPLE_W-1:0]    in_data,
   input  logic                     out_full,
   output logic                     out_push,
   output logic [MAP_W:0]           out_data,
   input  level_array_type          levels
);

   localparam logic [CNT_W-1:0]    SAMPLES_CNT = CNT_W'(SAMPLES);
   localparam logic [SAMPLE_W-1:0] JUMP_LIM    = SAMPLE_W'(JUMP_LIMIT);
   localparam logic [CODE_W-1:0]   LAST_IDX    = CODE_W'(NUM_LEVELS - 1);

   state_type state_ff, state_in;

   sample_type        samp_ff [NUM_CH];
   sample_type        samp_in [NUM_CH];
   logic [SUM_W-1:0]  sum_ff [NUM_CH];
   logic [SUM_W-1:0]  sum_in [NUM_CH];
   logic [SUM_W-1:0]  sum_new [NUM_CH];
   logic [CNT_W-1:0]  count_ff, count_in, count_new;
   logic              jump_ff, jump_in;
   sample_type        mean_ff [NUM_CH];
   sample_type        mean_in [NUM_CH];
   logic [CODE_W-1:0] idx_ff, idx_in;
   logic              below_v_ff [NUM_CH];
   logic              below_v_in [NUM_CH];
   sample_type        below_val_ff [NUM_CH];
   sample_type        below_val_in [NUM_CH];
   logic [CODE_W-1:0] below_idx_ff [NUM_CH];
   logic [CODE_W-1:0] below_idx_in [NUM_CH];
   logic              above_v_ff [NUM_CH];
   logic              above_v_in [NUM_CH];
   sample_type        above_val_ff [NUM_CH];
   sample_type        above_val_in [NUM_CH];
   logic [CODE_W-1:0] above_idx_ff [NUM_CH];
   logic [CODE_W-1:0] above_idx_in [NUM_CH];
   logic [MAP_W-1:0]  held_ff, held_in;
   logic              updated_ff, updated_in;

   logic              div_start;
   logic [CNT_W-1:0]  div_divisor;
   logic [SUM_W-1:0]  div_dividend [NUM_CH];
   logic              div_busy [NUM_CH];
   logic              div_done [NUM_CH];
   logic [SUM_W-1:0]  div_quot [NUM_CH];

   sample_type        lvl;
   sample_type        mean_now;
   sample_type        abs_diff;
   logic [CODE_W-1:0] code [NUM_CH];
   sample_type        d_up, d_down;

   assign lvl      = levels[idx_ff];
   assign out_data = {held_ff, updated_ff};

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_div
      abd_divider u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (div_dividend[ch]),
         .divisor  (div_divisor),
         .busy     (div_busy[ch]),
         .done     (div_done[ch]),
         .quotient (div_quot[ch])
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      jump_in    = jump_ff;
      idx_in     = idx_ff;
      held_in    = held_ff;
      updated_in = updated_ff;
      in_pop     = 1'b0;
      out_push   = 1'b0;
      div_start  = 1'b0;
      div_divisor = (state_ff == ST_IDLE) ? count_ff : SAMPLES_CNT;
      count_new  = (jump_ff ? '0 : count_ff) + 1'b1;
      mean_now   = '0;
      abs_diff   = '0;
      d_up       = '0;
      d_down     = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         samp_in[ch]      = samp_ff[ch];
         sum_in[ch]       = sum_ff[ch];
         mean_in[ch]      = mean_ff[ch];
         below_v_in[ch]   = below_v_ff[ch];
         below_val_in[ch] = below_val_ff[ch];
         below_idx_in[ch] = below_idx_ff[ch];
         above_v_in[ch]   = above_v_ff[ch];
         above_val_in[ch] = above_val_ff[ch];
         above_idx_in[ch] = above_idx_ff[ch];
         sum_new[ch]      = (jump_ff ? '0 : sum_ff[ch]) + SUM_W'(samp_ff[ch]);
         div_dividend[ch] = (state_ff == ST_IDLE) ? sum_ff[ch] : sum_new[ch];
         code[ch]         = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            jump_in = 1'b0;
            if (!in_empty) begin
               in_pop     = 1'b1;
               samp_in[0] = in_data[2*SAMPLE_W-1:SAMPLE_W];
               samp_in[1] = in_data[SAMPLE_W-1:0];
               if (count_ff != '0) begin
                  div_start = 1'b1;
                  state_in  = ST_MEAN;
               end else begin
                  state_in  = ST_ACCUM;
               end
            end
         end
         ST_MEAN: begin
            if (div_done[0]) begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  mean_now = div_quot[ch][SAMPLE_W-1:0];
                  abs_diff = (samp_ff[ch] > mean_now) ? samp_ff[ch] - mean_now
                                                      : mean_now - samp_ff[ch];
                  if (abs_diff > JUMP_LIM) begin
                     jump_in = 1'b1;
                  end
               end
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               sum_in[ch] = sum_new[ch];
            end
            count_in = count_new;
            if (count_new == SAMPLES_CNT) begin
               div_start = 1'b1;
               state_in  = ST_WIN;
            end else begin
               updated_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_WIN: begin
            if (div_done[0]) begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  mean_in[ch]    = div_quot[ch][SAMPLE_W-1:0];
                  below_v_in[ch] = 1'b0;
                  above_v_in[ch] = 1'b0;
               end
               idx_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // one level per cycle, both channels side by side
            for (int ch = 0; ch < NUM_CH; ch++) begin
               if (mean_ff[ch] > lvl) begin
                  if (!below_v_ff[ch] || (below_val_ff[ch] < lvl)) begin
                     below_v_in[ch]   = 1'b1;
                     below_val_in[ch] = lvl;
                     below_idx_in[ch] = idx_ff;
                  end
               end else begin
                  if (!above_v_ff[ch] || (above_val_ff[ch] > lvl)) begin
                     above_v_in[ch]   = 1'b1;
                     above_val_in[ch] = lvl;
                     above_idx_in[ch] = idx_ff;
                  end
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               d_up   = above_val_ff[ch] - mean_ff[ch];
               d_down = mean_ff[ch] - below_val_ff[ch];
               if (!above_v_ff[ch]) begin
                  code[ch] = below_idx_ff[ch];
               end else if (!below_v_ff[ch]) begin
                  code[ch] = above_idx_ff[ch];
               end else begin
                  code[ch] = (d_up > d_down) ? below_idx_ff[ch] : above_idx_ff[ch];
               end
               sum_in[ch] = '0;
            end
            held_in    = {code[0], code[1]};
            count_in   = '0;
            updated_in = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         jump_ff  <= 1'b0;
         held_ff  <= '0;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_ff[ch] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         jump_ff  <= jump_in;
         held_ff  <= held_in;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_ff[ch] <= sum_in[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      updated_ff <= updated_in;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         samp_ff[ch]      <= samp_in[ch];
         mean_ff[ch]      <= mean_in[ch];
         below_v_ff[ch]   <= below_v_in[ch];
         below_val_ff[ch] <= below_val_in[ch];
         below_idx_ff[ch] <= below_idx_in[ch];
         above_v_ff[ch]   <= above_v_in[ch];
         above_val_ff[ch] <= above_val_in[ch];
         above_idx_ff[ch] <= above_idx_in[ch];
      end
   end

   // a window never stays full between items
   a_count_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff < SAMPLES_CNT))
      else $error("sample count reached window length while idle");

   // the divider is never restarted mid-division
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy[0] && !div_busy[1])
      else $error("divider started while busy");

   // a result pushed returns the sequencer to idle
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      out_push |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after a result");

   // a completed window always reports an update
   a_window_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |=> updated_ff && (count_ff == '0))
      else $error("window completion not flagged");

endmodule
